// ===== rtl/dcc_pkg.sv =====
// Types and fixed constants for the DCC packet bit generator.
// No dependencies; imported by dcc_packet_bit_generator_top.
package dcc_pkg;

   localparam int PERIOD_W = 16;
   localparam int COUNT_W  = 4;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_COMMIT = 2'd2;

   localparam logic [1:0] LOAD_NONE     = 2'd0;
   localparam logic [1:0] LOAD_ACCEPTED = 2'd1;
   localparam logic [1:0] LOAD_REJECTED = 2'd2;

   localparam logic [1:0] REG_ONE_HALF  = 2'd0;
   localparam logic [1:0] REG_ZERO_HIGH = 2'd1;
   localparam logic [1:0] REG_ZERO_LOW  = 2'd2;

   localparam logic [PERIOD_W-1:0] ONE_HALF_RESET  = 16'd115;
   localparam logic [PERIOD_W-1:0] ZERO_HIGH_RESET = 16'd199;
   localparam logic [PERIOD_W-1:0] ZERO_LOW_RESET  = 16'd199;

   localparam logic [COUNT_W-1:0] BYTE_LAST_BIT = 4'd7;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         byte_value;
      logic [2:0]         byte_index;
      logic [COUNT_W-1:0] byte_count;
   } req_type;

   typedef struct packed {
      logic                line_level;
      logic [PERIOD_W-1:0] half_period;
      logic                need_packet;
      logic [1:0]          load_status;
   } rsp_type;

endpackage

// ===== rtl/dcc_packet_bit_generator_top.sv =====
// DCC track waveform generator: one item per cycle unless req_stall is high; the result
// appears in the cycle after acceptance. Each tick item ends one half-period; the line
// toggles and, on a rising half, the frame state machine picks the next bit (idle ones,
// preamble, start bit, data MSB first, end bit). Byte-write and commit items load the
// packet buffer and length. The block takes an item in any cycle with req_stall low;
// a single result register separates the two channels, so req_stall rises only while a
// result is held by rsp_stall. Configuration writes are always ready. Depends on dcc_pkg.
module dcc_packet_bit_generator_top #(
   parameter int MAX_PACKET_BYTES    = 6,
   parameter int PREAMBLE_LAST_INDEX = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dcc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dcc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);
   import dcc_pkg::*;

   localparam int IDX_W = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;

   localparam logic [2:0] FS_IDLE     = 3'd0;
   localparam logic [2:0] FS_PREAMBLE = 3'd1;
   localparam logic [2:0] FS_BSTART   = 3'd2;
   localparam logic [2:0] FS_BYTE     = 3'd3;
   localparam logic [2:0] FS_END      = 3'd4;

   logic [PERIOD_W-1:0] one_half_ff, zero_high_ff, zero_low_ff;
   logic [7:0]          buffer_ff [MAX_PACKET_BYTES];
   logic [COUNT_W-1:0]  length_ff, length_in;
   logic [COUNT_W-1:0]  remaining_ff, remaining_in;
   logic [COUNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [2:0]          frame_ff, frame_in;
   logic                level_ff, level_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                zero_ff, zero_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                accept;
   logic                wr_en;
   logic [COUNT_W-1:0]  pos;
   logic                rd_ok;
   logic [7:0]          rd_byte;
   logic [1:0]          status;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pos     = length_ff - remaining_ff;
   assign rd_ok   = (remaining_ff <= length_ff) && (pos < COUNT_W'(MAX_PACKET_BYTES));
   assign rd_byte = rd_ok ? buffer_ff[pos[IDX_W-1:0]] : 8'd0;
   assign wr_en   = accept && (req_data.cmd == CMD_WRITE)
                    && ({1'b0, req_data.byte_index} < COUNT_W'(MAX_PACKET_BYTES));

   always_comb begin
      length_in    = length_ff;
      remaining_in = remaining_ff;
      bit_count_in = bit_count_ff;
      frame_in     = frame_ff;
      level_in     = level_ff;
      period_in    = period_ff;
      zero_in      = zero_ff;
      status       = LOAD_NONE;
      case (req_data.cmd)
         CMD_TICK: begin
            level_in = ~level_ff;
            if (level_in) begin
               case (frame_ff)
                  FS_IDLE: begin
                     period_in = one_half_ff;
                     zero_in   = 1'b0;
                     if (remaining_ff != '0) begin
                        if (bit_count_ff == '0) begin
                           frame_in = FS_BSTART;
                        end else begin
                           frame_in     = FS_PREAMBLE;
                           bit_count_in = bit_count_ff - 1'b1;
                        end
                     end
                  end
                  FS_PREAMBLE: begin
                     period_in = one_half_ff;
                     zero_in   = 1'b0;
                     if (bit_count_ff == '0) begin
                        frame_in = FS_BSTART;
                     end else begin
                        bit_count_in = bit_count_ff - 1'b1;
                     end
                  end
                  FS_BSTART: begin
                     period_in    = zero_high_ff;
                     zero_in      = 1'b1;
                     frame_in     = FS_BYTE;
                     bit_count_in = BYTE_LAST_BIT;
                  end
                  FS_BYTE: begin
                     if (rd_byte[bit_count_ff[2:0]]) begin
                        period_in = one_half_ff;
                        zero_in   = 1'b0;
                     end else begin
                        period_in = zero_high_ff;
                        zero_in   = 1'b1;
                     end
                     if (bit_count_ff == '0) begin
                        if (remaining_ff <= COUNT_W'(1)) begin
                           remaining_in = '0;
                           frame_in     = FS_END;
                        end else begin
                           remaining_in = remaining_ff - 1'b1;
                           frame_in     = FS_BSTART;
                        end
                     end else begin
                        bit_count_in = bit_count_ff - 1'b1;
                     end
                  end
                  default: begin
                     period_in    = one_half_ff;
                     zero_in      = 1'b0;
                     frame_in     = FS_IDLE;
                     bit_count_in = COUNT_W'(PREAMBLE_LAST_INDEX);
                  end
               endcase
            end else if (zero_ff) begin
               period_in = zero_low_ff;
            end
         end
         CMD_COMMIT: begin
            if (req_data.byte_count <= COUNT_W'(MAX_PACKET_BYTES)) begin
               length_in    = req_data.byte_count;
               remaining_in = req_data.byte_count;
               status       = LOAD_ACCEPTED;
            end else begin
               status = LOAD_REJECTED;
            end
         end
         default: begin
            status = LOAD_NONE;
         end
      endcase

      rsp_in.line_level  = level_in;
      rsp_in.half_period = period_in;
      rsp_in.need_packet = (remaining_in == '0);
      rsp_in.load_status = status;
      rsp_valid_in       = accept | req_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_half_ff  <= ONE_HALF_RESET;
         zero_high_ff <= ZERO_HIGH_RESET;
         zero_low_ff  <= ZERO_LOW_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ONE_HALF:  one_half_ff  <= csr_data;
            REG_ZERO_HIGH: zero_high_ff <= csr_data;
            REG_ZERO_LOW:  zero_low_ff  <= csr_data;
            default:       one_half_ff  <= one_half_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
            buffer_ff[i] <= 8'd0;
         end
      end else if (wr_en) begin
         buffer_ff[req_data.byte_index[IDX_W-1:0]] <= req_data.byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         remaining_ff <= '0;
         bit_count_ff <= COUNT_W'(PREAMBLE_LAST_INDEX);
         frame_ff     <= FS_IDLE;
         level_ff     <= 1'b0;
         period_ff    <= ONE_HALF_RESET;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            length_ff    <= length_in;
            remaining_ff <= remaining_in;
            bit_count_ff <= bit_count_in;
            frame_ff     <= frame_in;
            level_ff     <= level_in;
            period_ff    <= period_in;
            zero_ff      <= zero_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
